FILE: rtl/sct_pkg.sv
// -----------------------------------------------------------------------------
// sct_pkg
// Shared types and codes of the sparse CSR to CSC transpose core: request
// and response words, field widths, mode and kind codes, register indexes
// and the sequencer states.
// -----------------------------------------------------------------------------
package sct_pkg;

   localparam int ROW_W  = 10;
   localparam int COL_W  = 10;
   localparam int VAL_W  = 64;
   localparam int IDX_W  = 12;
   localparam int DIM_W  = 11;
   localparam int PTR_W  = 13;
   localparam int ROWO_W = 11;
   localparam int LD_W   = ROW_W + COL_W + VAL_W;
   localparam int OUT_W  = ROW_W + VAL_W;

   localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

   // request modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_PTR  = 2'd1;
   localparam logic [1:0] MODE_SLOT = 2'd2;

   // response kinds
   localparam logic [1:0] KIND_DONE = 2'd0;
   localparam logic [1:0] KIND_PTR  = 2'd1;
   localparam logic [1:0] KIND_SLOT = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_DIMENSION  = 2'd0;
   localparam logic [1:0] CSR_INDEX_BASE = 2'd1;

   typedef struct packed {
      logic [1:0]       mode;
      logic [ROW_W-1:0] row_in;
      logic [COL_W-1:0] col_in;
      logic [VAL_W-1:0] value_in;
      logic             last_entry;
      logic [IDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [PTR_W-1:0]  pointer;
      logic [ROWO_W-1:0] row_out;
      logic [VAL_W-1:0]  value_out;
      logic              fault;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_PTR,
      ST_RD_SLOT,
      ST_ZERO,
      ST_CNT_RD,
      ST_CNT_COL,
      ST_CNT_WR,
      ST_PFX_RD,
      ST_PFX_WR,
      ST_PFX_END,
      ST_SCT_RD,
      ST_SCT_COL,
      ST_SCT_WR,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/sct_ram.sv
// -----------------------------------------------------------------------------
// sct_ram
// Generic memory: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module sct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/sct_ctrl.sv
// -----------------------------------------------------------------------------
// sct_ctrl
// Sequencer of the transpose core: takes requests, walks the stored entries
// to count, prefix-sum and scatter them, and serves pointer and slot reads.
// One shared adder does the count, pointer and cursor arithmetic.
// -----------------------------------------------------------------------------
module sct_ctrl
   import sct_pkg::*;
#(
   parameter int MAX_DIM = 1024,
   parameter int MAX_NNZ = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  req_type                          req_data,
   input  logic [DIM_W-1:0]                 dim,
   input  logic                             base,
   output logic                             busy,
   output logic                             rsp_valid,
   output rsp_type                          rsp_data,
   output logic                             load_we,
   output logic [$clog2(MAX_NNZ)-1:0]       load_waddr,
   output logic [LD_W-1:0]                  load_wdata,
   output logic [$clog2(MAX_NNZ)-1:0]       load_raddr,
   input  logic [LD_W-1:0]                  load_rdata,
   output logic                             cnt_we,
   output logic [$clog2(MAX_DIM+1)-1:0]     cnt_waddr,
   output logic [$clog2(MAX_NNZ+1)-1:0]     cnt_wdata,
   output logic [$clog2(MAX_DIM+1)-1:0]     cnt_raddr,
   input  logic [$clog2(MAX_NNZ+1)-1:0]     cnt_rdata,
   output logic                             fill_we,
   output logic [$clog2(MAX_DIM)-1:0]       fill_waddr,
   output logic [$clog2(MAX_NNZ+1)-1:0]     fill_wdata,
   output logic [$clog2(MAX_DIM)-1:0]       fill_raddr,
   input  logic [$clog2(MAX_NNZ+1)-1:0]     fill_rdata,
   output logic                             out_we,
   output logic [$clog2(MAX_NNZ)-1:0]       out_waddr,
   output logic [OUT_W-1:0]                 out_wdata,
   output logic [$clog2(MAX_NNZ)-1:0]       out_raddr,
   input  logic [OUT_W-1:0]                 out_rdata
);

   localparam int CAW = $clog2(MAX_DIM + 1);
   localparam int FAW = $clog2(MAX_DIM);
   localparam int NAW = $clog2(MAX_NNZ);
   localparam int CW  = $clog2(MAX_NNZ + 1);

   state_type state_ff, state_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CAW-1:0] col_ff, col_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic [CW-1:0]  placed_ff, placed_in;
   logic [CW-1:0]  entry_count_ff, entry_count_in;
   logic [CW-1:0]  csc_count_ff, csc_count_in;
   logic           dropped_ff, dropped_in;
   logic           finished_ff, finished_in;
   logic           ok_ff, ok_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           accept;
   logic [CW-1:0]  idx_inc;
   logic           idx_last;
   logic           col_at_dim;
   logic           col_at_max;
   logic [ROW_W-1:0] ld_row;
   logic [COL_W-1:0] ld_col;
   logic           ld_col_ok;
   logic [CW-1:0]  eff_count;
   logic           store_ok;
   logic           ptr_ok;
   logic           slot_ok;
   logic [CW-1:0]  add_a, add_b, add_sum;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign idx_inc    = idx_ff + CW'(1);
   assign idx_last   = (idx_inc == entry_count_ff);
   assign col_at_dim = (32'(col_ff) == 32'(dim));
   assign col_at_max = (32'(col_ff) == MAX_DIM);

   assign ld_row    = load_rdata[LD_W-1 -: ROW_W];
   assign ld_col    = load_rdata[VAL_W +: COL_W];
   assign ld_col_ok = (32'(ld_col) < 32'(dim));

   assign eff_count = finished_ff ? '0 : entry_count_ff;
   assign store_ok  = (32'(eff_count) < MAX_NNZ) && (32'(req_data.col_in) < 32'(dim));
   assign ptr_ok    = (32'(req_data.read_index) <= 32'(dim));
   assign slot_ok   = (32'(req_data.read_index) < 32'(csc_count_ff));

   // shared adder: column counts, running pointer and fill cursors
   always_comb begin
      unique case (state_ff)
         ST_PFX_WR: begin
            add_a = ptr_ff;
            add_b = cnt_rdata;
         end
         ST_SCT_WR: begin
            add_a = fill_rdata;
            add_b = CW'(1);
         end
         default: begin
            add_a = cnt_rdata;
            add_b = CW'(1);
         end
      endcase
   end
   assign add_sum = add_a + add_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (col_at_max) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_LOAD: if (req_data.last_entry) state_in = ST_ZERO;
                  MODE_PTR:  state_in = ST_RD_PTR;
                  MODE_SLOT: state_in = ST_RD_SLOT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_PTR, ST_RD_SLOT: state_in = ST_IDLE;
         ST_ZERO: begin
            if (col_at_dim) begin
               state_in = (entry_count_ff == '0) ? ST_PFX_RD : ST_CNT_RD;
            end
         end
         ST_CNT_RD: state_in = ST_CNT_COL;
         ST_CNT_COL: begin
            if (ld_col_ok)     state_in = ST_CNT_WR;
            else if (idx_last) state_in = ST_PFX_RD;
            else               state_in = ST_CNT_RD;
         end
         ST_CNT_WR: state_in = idx_last ? ST_PFX_RD : ST_CNT_RD;
         ST_PFX_RD: state_in = ST_PFX_WR;
         ST_PFX_WR: begin
            state_in = (32'(col_ff) + 1 == 32'(dim)) ? ST_PFX_END : ST_PFX_RD;
         end
         ST_PFX_END: state_in = (entry_count_ff == '0) ? ST_DONE : ST_SCT_RD;
         ST_SCT_RD:  state_in = ST_SCT_COL;
         ST_SCT_COL: begin
            if (ld_col_ok)     state_in = ST_SCT_WR;
            else if (idx_last) state_in = ST_DONE;
            else               state_in = ST_SCT_RD;
         end
         ST_SCT_WR: state_in = idx_last ? ST_DONE : ST_SCT_RD;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory controls and register updates
   always_comb begin
      idx_in         = idx_ff;
      col_in         = col_ff;
      ptr_in         = ptr_ff;
      placed_in      = placed_ff;
      entry_count_in = entry_count_ff;
      csc_count_in   = csc_count_ff;
      dropped_in     = dropped_ff;
      finished_in    = finished_ff;
      ok_in          = ok_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;

      load_we    = 1'b0;
      load_waddr = NAW'(eff_count);
      load_wdata = {req_data.row_in, req_data.col_in, req_data.value_in};
      load_raddr = NAW'(idx_ff);
      cnt_we     = 1'b0;
      cnt_waddr  = col_ff;
      cnt_wdata  = '0;
      cnt_raddr  = col_ff;
      fill_we    = 1'b0;
      fill_waddr = FAW'(col_ff);
      fill_wdata = ptr_ff;
      fill_raddr = FAW'(ld_col);
      out_we     = 1'b0;
      out_waddr  = NAW'(fill_rdata);
      out_wdata  = {ld_row, load_rdata[VAL_W-1:0]};
      out_raddr  = slot_ok ? NAW'(req_data.read_index) : '0;

      unique case (state_ff)
         // zero the pointer table after reset
         ST_CLEAR: begin
            cnt_we = 1'b1;
            col_in = col_ff + CAW'(1);
         end
         ST_IDLE: begin
            cnt_raddr = ptr_ok ? CAW'(req_data.read_index) : '0;
            if (accept) begin
               case (req_data.mode)
                  MODE_LOAD: begin
                     load_we        = store_ok;
                     entry_count_in = store_ok ? eff_count + CW'(1) : eff_count;
                     dropped_in     = (dropped_ff && !finished_ff) || !store_ok;
                     finished_in    = 1'b0;
                     idx_in         = '0;
                     col_in         = '0;
                     ptr_in         = '0;
                     placed_in      = '0;
                  end
                  MODE_PTR:  ok_in = ptr_ok;
                  MODE_SLOT: ok_in = slot_ok;
                  default:   ok_in = ok_ff;
               endcase
            end
         end
         ST_RD_PTR: begin
            rsp_valid_in      = 1'b1;
            rsp_in.kind       = KIND_PTR;
            rsp_in.pointer    = ok_ff ? PTR_W'(cnt_rdata) + PTR_W'(base) : '0;
            rsp_in.row_out    = '0;
            rsp_in.value_out  = '0;
            rsp_in.fault      = dropped_ff || !ok_ff;
         end
         ST_RD_SLOT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.kind       = KIND_SLOT;
            rsp_in.pointer    = '0;
            rsp_in.row_out    = ok_ff ? ROWO_W'(out_rdata[OUT_W-1 -: ROW_W]) + ROWO_W'(base)
                                      : '0;
            rsp_in.value_out  = ok_ff ? out_rdata[VAL_W-1:0] : '0;
            rsp_in.fault      = dropped_ff || !ok_ff;
         end
         // clear the counts of columns 0..dim
         ST_ZERO: begin
            cnt_we = 1'b1;
            col_in = col_at_dim ? '0 : col_ff + CAW'(1);
         end
         ST_CNT_RD: begin
         end
         // count the entry, or drop it if its column left the range
         ST_CNT_COL: begin
            cnt_raddr = CAW'(ld_col);
            if (!ld_col_ok) begin
               dropped_in = 1'b1;
               idx_in     = idx_last ? '0 : idx_inc;
            end
         end
         ST_CNT_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = CAW'(ld_col);
            cnt_wdata = add_sum;
            idx_in    = idx_last ? '0 : idx_inc;
         end
         ST_PFX_RD: begin
         end
         // turn a count into a start pointer and seed the fill cursor
         ST_PFX_WR: begin
            cnt_we    = 1'b1;
            cnt_wdata = ptr_ff;
            fill_we   = 1'b1;
            ptr_in    = add_sum;
            col_in    = col_ff + CAW'(1);
         end
         ST_PFX_END: begin
            cnt_we    = 1'b1;
            cnt_waddr = CAW'(dim);
            cnt_wdata = ptr_ff;
         end
         ST_SCT_RD: begin
         end
         ST_SCT_COL: begin
            if (!ld_col_ok) idx_in = idx_last ? '0 : idx_inc;
         end
         // place the entry at its column cursor and advance the cursor
         ST_SCT_WR: begin
            fill_we    = 1'b1;
            fill_waddr = FAW'(ld_col);
            fill_wdata = add_sum;
            out_we     = 1'b1;
            placed_in  = placed_ff + CW'(1);
            idx_in     = idx_last ? '0 : idx_inc;
         end
         ST_DONE: begin
            entry_count_in   = placed_ff;
            csc_count_in     = placed_ff;
            finished_in      = 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_in.kind      = KIND_DONE;
            rsp_in.pointer   = PTR_W'(placed_ff);
            rsp_in.row_out   = '0;
            rsp_in.value_out = '0;
            rsp_in.fault     = dropped_ff;
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         col_ff         <= '0;
         entry_count_ff <= '0;
         csc_count_ff   <= '0;
         dropped_ff     <= 1'b0;
         finished_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         col_ff         <= col_in;
         entry_count_ff <= entry_count_in;
         csc_count_ff   <= csc_count_in;
         dropped_ff     <= dropped_in;
         finished_ff    <= finished_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      ptr_ff    <= ptr_in;
      placed_ff <= placed_in;
      ok_ff     <= ok_in;
      rsp_ff    <= rsp_in;
   end

endmodule

FILE: rtl/sparse_csr_to_csc_transpose_core.sv
// -----------------------------------------------------------------------------
// sparse_csr_to_csc_transpose_core
// Sparse matrix transpose: CSR nonzeros in, column pointers and transposed
// slots out.
// -----------------------------------------------------------------------------
// A load word gives no response unless it carries the last mark. Pointer
// and slot reads answer through the read state and the registered response
// word, with busy high for one cycle. The last load word starts the
// transpose, which holds busy through a zeroing sweep of the pointer table,
// a counting pass, a prefix pass and a scatter pass, each stepping one
// memory access at a time; the counting, prefix and scatter passes share one
// adder. After reset a clearing pass zeroes all MAX_DIM + 1 entries of the
// pointer table with busy high; register writes are taken during it. Each
// response word is shown for one cycle on rsp_valid and cannot be held off.
// -----------------------------------------------------------------------------
module sparse_csr_to_csc_transpose_core
   import sct_pkg::*;
#(
   parameter int MAX_DIM = 1024,
   parameter int MAX_NNZ = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_data
);

   localparam int CAW = $clog2(MAX_DIM + 1);
   localparam int FAW = $clog2(MAX_DIM);
   localparam int NAW = $clog2(MAX_NNZ);
   localparam int CW  = $clog2(MAX_NNZ + 1);

   logic [DIM_W-1:0] dimension_ff;
   logic             index_base_ff;
   logic [DIM_W-1:0] dim;

   logic             load_we;
   logic [NAW-1:0]   load_waddr, load_raddr;
   logic [LD_W-1:0]  load_wdata, load_rdata;
   logic             cnt_we;
   logic [CAW-1:0]   cnt_waddr, cnt_raddr;
   logic [CW-1:0]    cnt_wdata, cnt_rdata;
   logic             fill_we;
   logic [FAW-1:0]   fill_waddr, fill_raddr;
   logic [CW-1:0]    fill_wdata, fill_rdata;
   logic             out_we;
   logic [NAW-1:0]   out_waddr, out_raddr;
   logic [OUT_W-1:0] out_wdata, out_rdata;

   assign csr_ready = 1'b1;

   // hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff  <= DIM_RESET;
         index_base_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DIMENSION:  dimension_ff  <= csr_data;
            CSR_INDEX_BASE: index_base_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // clamp the dimension into 1..MAX_DIM
   always_comb begin
      if (dimension_ff == '0) begin
         dim = DIM_W'(1);
      end else if (32'(dimension_ff) > MAX_DIM) begin
         dim = DIM_W'(MAX_DIM);
      end else begin
         dim = dimension_ff;
      end
   end

   sct_ctrl #(
      .MAX_DIM (MAX_DIM),
      .MAX_NNZ (MAX_NNZ)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .dim        (dim),
      .base       (index_base_ff),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .load_we    (load_we),
      .load_waddr (load_waddr),
      .load_wdata (load_wdata),
      .load_raddr (load_raddr),
      .load_rdata (load_rdata),
      .cnt_we     (cnt_we),
      .cnt_waddr  (cnt_waddr),
      .cnt_wdata  (cnt_wdata),
      .cnt_raddr  (cnt_raddr),
      .cnt_rdata  (cnt_rdata),
      .fill_we    (fill_we),
      .fill_waddr (fill_waddr),
      .fill_wdata (fill_wdata),
      .fill_raddr (fill_raddr),
      .fill_rdata (fill_rdata),
      .out_we     (out_we),
      .out_waddr  (out_waddr),
      .out_wdata  (out_wdata),
      .out_raddr  (out_raddr),
      .out_rdata  (out_rdata)
   );

   // loaded entries: row, column, value
   sct_ram #(.WIDTH(LD_W), .DEPTH(MAX_NNZ)) u_load_ram (
      .clock (clock), .we (load_we), .waddr (load_waddr), .wdata (load_wdata),
      .raddr (load_raddr), .rdata (load_rdata)
   );

   // column counts, then column start pointers
   sct_ram #(.WIDTH(CW), .DEPTH(MAX_DIM + 1)) u_cnt_ram (
      .clock (clock), .we (cnt_we), .waddr (cnt_waddr), .wdata (cnt_wdata),
      .raddr (cnt_raddr), .rdata (cnt_rdata)
   );

   // per-column fill cursors
   sct_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_fill_ram (
      .clock (clock), .we (fill_we), .waddr (fill_waddr), .wdata (fill_wdata),
      .raddr (fill_raddr), .rdata (fill_rdata)
   );

   // transposed slots: row, value
   sct_ram #(.WIDTH(OUT_W), .DEPTH(MAX_NNZ)) u_out_ram (
      .clock (clock), .we (out_we), .waddr (out_waddr), .wdata (out_wdata),
      .raddr (out_raddr), .rdata (out_rdata)
   );

endmodule

FILE: sim/sparse_csr_to_csc_transpose_core_tb.sv
// -----------------------------------------------------------------------------
// sparse_csr_to_csc_transpose_core_tb
// Self-checking bench for the sparse CSR to CSC transpose core. It loads
// small matrices with random content under many dimension and base settings,
// reads back column pointers and transposed slots, and checks every response
// word against an in-bench model.
// -----------------------------------------------------------------------------
module sparse_csr_to_csc_transpose_core_tb;
   import sct_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM    = 1024;
   localparam int MAX_NNZ    = 4096;
   localparam int IDLE_LIMIT = 100000;
   localparam int RAND_ITEMS = 1000;

   // Model of the transpose: loaded entries, CSC store, pending responses
   class transpose_scoreboard;
      bit [ROW_W-1:0]   load_rows[MAX_NNZ];
      bit [COL_W-1:0]   load_cols[MAX_NNZ];
      bit [VAL_W-1:0]   load_values[MAX_NNZ];
      int unsigned      col_start[MAX_DIM+1];
      int unsigned      fill_next[MAX_DIM];
      bit [ROW_W-1:0]   csc_rows[MAX_NNZ];
      bit [VAL_W-1:0]   csc_values[MAX_NNZ];
      int unsigned      entry_count;
      int unsigned      csc_count;
      bit               dropped;
      bit               finished;
      bit [DIM_W-1:0]   dim_reg;
      bit               base_reg;
      rsp_type          pending[$];
      int               errors;

      function new();
         dim_reg = DIM_RESET;
      endfunction

      function void write_reg(logic [1:0] idx, logic [DIM_W-1:0] data);
         if (idx == CSR_DIMENSION)
            dim_reg = data;
         else if (idx == CSR_INDEX_BASE)
            base_reg = data[0];
      endfunction

      function int unsigned live_dim();
         if (dim_reg == 0)
            return 1;
         if (dim_reg > MAX_DIM)
            return MAX_DIM;
         return dim_reg;
      endfunction

      // Append one predicted word at the tail
      function void queue_word(rsp_type e);
         pending.insert(pending.size(), e);
      endfunction

      // Predict the response of one accepted word
      function void note_request(req_type r);
         int unsigned dim;
         int unsigned ridx;
         int unsigned ptr;
         int unsigned placed;
         int unsigned n;
         int unsigned slot;
         bit          ok;
         rsp_type     e;
         dim  = live_dim();
         ridx = r.read_index;
         e    = '0;
         case (r.mode)
            MODE_LOAD: begin
               if (finished) begin
                  entry_count = 0;
                  dropped     = 0;
                  finished    = 0;
               end
               if (entry_count < MAX_NNZ && r.col_in < dim) begin
                  load_rows[entry_count]   = r.row_in;
                  load_cols[entry_count]   = r.col_in;
                  load_values[entry_count] = r.value_in;
                  entry_count++;
               end else begin
                  dropped = 1;
               end
               if (r.last_entry) begin
                  // count, prefix-sum, then scatter in arrival order
                  for (int c = 0; c <= dim; c++)
                     col_start[c] = 0;
                  for (int i = 0; i < entry_count; i++) begin
                     if (load_cols[i] < dim)
                        col_start[load_cols[i]]++;
                     else
                        dropped = 1;
                  end
                  ptr = 0;
                  for (int c = 0; c < dim; c++) begin
                     n            = col_start[c];
                     col_start[c] = ptr;
                     fill_next[c] = ptr;
                     ptr += n;
                  end
                  col_start[dim] = ptr;
                  placed = 0;
                  for (int i = 0; i < entry_count; i++) begin
                     if (load_cols[i] < dim) begin
                        slot = fill_next[load_cols[i]]++;
                        if (slot < MAX_NNZ) begin
                           csc_rows[slot]   = load_rows[i];
                           csc_values[slot] = load_values[i];
                           placed++;
                        end
                     end
                  end
                  csc_count   = placed;
                  entry_count = placed;
                  finished    = 1;
                  e.kind      = KIND_DONE;
                  e.pointer   = entry_count[PTR_W-1:0];
                  e.fault     = dropped;
                  queue_word(e);
               end
            end
            MODE_PTR: begin
               ok        = ridx <= dim;
               e.kind    = KIND_PTR;
               e.pointer = ok ? PTR_W'(col_start[ridx] + base_reg) : '0;
               e.fault   = dropped | !ok;
               queue_word(e);
            end
            MODE_SLOT: begin
               ok          = ridx < csc_count;
               e.kind      = KIND_SLOT;
               e.row_out   = ok ? ROWO_W'(csc_rows[ridx]) + ROWO_W'(base_reg) : '0;
               e.value_out = ok ? csc_values[ridx] : '0;
               e.fault     = dropped | !ok;
               queue_word(e);
            end
            default: ;
         endcase
      endfunction

      // Compare one response word with the oldest prediction
      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response word %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.kind !== e.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, e.kind, a.kind);
            errors++;
         end
         if (a.pointer !== e.pointer) begin
            $display("%0t: pointer expected %0d actual %0d", $time, e.pointer, a.pointer);
            errors++;
         end
         if (a.row_out !== e.row_out) begin
            $display("%0t: row_out expected %0d actual %0d", $time, e.row_out, a.row_out);
            errors++;
         end
         if (a.value_out !== e.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time, e.value_out,
                     a.value_out);
            errors++;
         end
         if (a.fault !== e.fault) begin
            $display("%0t: fault expected %0b actual %0b", $time, e.fault, a.fault);
            errors++;
         end
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   req_type          req_data  = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = CSR_DIMENSION;
   logic [DIM_W-1:0] csr_data  = '0;

   transpose_scoreboard sb = new();
   int burst_left;
   int no_gap_left;
   int idle_cycles;
   int item_count;

   sparse_csr_to_csc_transpose_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Check every response word as it is shown
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_data);
   end

   // Watchdog: count cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type make_word(logic [1:0] mode, int row, int col,
                                         logic [VAL_W-1:0] val, int last, int ridx);
      req_type r;
      r.mode       = mode;
      r.row_in     = ROW_W'(row);
      r.col_in     = COL_W'(col);
      r.value_in   = val;
      r.last_entry = 1'(last);
      r.read_index = IDX_W'(ridx);
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Send one word; hold start until the core takes it, then maybe pause
   task automatic send(req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      item_count++;
      if (no_gap_left > 0) begin
         no_gap_left--;
      end else if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = $urandom_range(0, 10);
         if ($urandom_range(0, 9) == 0)
            no_gap_left = $urandom_range(10, 40);
      end
   endtask

   // Drop start and wait until every response has arrived
   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [DIM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Load one matrix with random content, then read it back
   task automatic random_matrix();
      int unsigned dim;
      int n;
      int m;
      int col;
      int span;
      dim = sb.live_dim();
      n   = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
         col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, dim - 1);
         send(make_word(MODE_LOAD, $urandom_range(0, 1023), col, rand_value(),
                        i == n - 1, $urandom()));
         if ($urandom_range(0, 19) == 0)
            send(make_word(MODE_PTR, 0, 0, '0, $urandom_range(0, 1),
                           $urandom_range(0, dim)));
      end
      m = $urandom_range(2, 15);
      for (int i = 0; i < m; i++) begin
         span = (sb.csc_count > 0) ? sb.csc_count : 1;
         case ($urandom_range(0, 9))
            0: send(make_word(2'd3, $urandom(), $urandom(), rand_value(),
                              $urandom_range(0, 1), $urandom()));
            1: send(make_word(2'($urandom_range(1, 2)), $urandom(), $urandom(),
                              rand_value(), $urandom_range(0, 1), $urandom()));
            2, 3, 4: send(make_word(MODE_PTR, 0, 0, '0, 0, $urandom_range(0, dim + 1)));
            default: send(make_word(MODE_SLOT, 0, 0, '0, 0, $urandom_range(0, span)));
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reads before any transpose, ignored words
      write_reg(CSR_DIMENSION, 11'd1024);
      write_reg(CSR_INDEX_BASE, 11'd0);
      send(make_word(MODE_PTR, 0, 0, '0, 0, 0));
      send(make_word(MODE_PTR, 0, 0, '0, 1, 1024));
      send(make_word(MODE_PTR, 0, 0, '0, 0, 4095));
      send(make_word(MODE_SLOT, 0, 0, '0, 1, 0));
      send(make_word(2'd3, 1023, 1023, '1, 1, 4095));

      // Extremes, then shrink the dimension before the last word
      send(make_word(MODE_LOAD, 0, 0, '0, 0, 0));
      send(make_word(MODE_LOAD, 1023, 1023, '1, 0, 4095));
      send(make_word(MODE_LOAD, 3, 1, 64'h0123456789abcdef, 0, 0));
      drain();
      write_reg(CSR_DIMENSION, 11'd2);
      send(make_word(MODE_LOAD, 9, 3, 64'h5a5a5a5a5a5a5a5a, 0, 0));
      send(make_word(MODE_LOAD, 2, 0, 64'hfedcba9876543210, 1, 0));
      for (int i = 0; i <= 3; i++)
         send(make_word(MODE_PTR, 0, 0, '0, 0, i));
      for (int i = 0; i <= 3; i++)
         send(make_word(MODE_SLOT, 0, 0, '0, 0, i));
      drain();

      // Base one, dimension register zero and above range
      write_reg(CSR_INDEX_BASE, 11'd1);
      write_reg(CSR_DIMENSION, 11'd0);
      send(make_word(MODE_PTR, 0, 0, '0, 0, 1));
      send(make_word(MODE_PTR, 0, 0, '0, 0, 2));
      send(make_word(MODE_SLOT, 0, 0, '0, 0, 0));
      drain();
      write_reg(CSR_DIMENSION, 11'd2047);
      send(make_word(MODE_LOAD, 1023, 1023, '1, 1, 0));
      send(make_word(MODE_PTR, 0, 0, '0, 0, 1024));
      send(make_word(MODE_SLOT, 0, 0, '0, 0, 0));
      drain();

      // Random matrices under changing settings
      while (item_count < RAND_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 11))
               0:       write_reg(CSR_DIMENSION, 11'd1024);
               1:       write_reg(CSR_DIMENSION, DIM_W'($urandom()));
               2:       write_reg(CSR_DIMENSION, 11'd0);
               3:       write_reg(CSR_DIMENSION, 11'd1);
               4:       write_reg(CSR_DIMENSION, DIM_W'($urandom_range(1, 64)));
               default: write_reg(CSR_DIMENSION, DIM_W'($urandom_range(1, 16)));
            endcase
            write_reg(CSR_INDEX_BASE, DIM_W'($urandom_range(0, 1)));
         end
         random_matrix();
         drain();
         // wide dimensions make each transpose long; step back to small ones
         if (sb.live_dim() > 64)
            write_reg(CSR_DIMENSION, DIM_W'($urandom_range(1, 16)));
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
